[design/hax_pkg.sv]
// Shared types and constants for the Hilbert axes-to-index encoder.
// No dependencies; used by every module of the design folder.
package hax_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int COORD_BITS = 16;
  localparam int DIM_W      = 3;
  localparam int BITS_W     = 5;
  localparam int PLANE_W    = $clog2(COORD_BITS);
  localparam int IDX_W      = MAX_DIMS * COORD_BITS;
  localparam int NUM_CELLS  = COORD_BITS - 1;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  // register indexes on the config port
  localparam logic REG_NUM_DIMS = 1'b0;
  localparam logic REG_BITS     = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef coord_t [MAX_DIMS-1:0] axes_t;

  typedef struct packed {
    logic  valid;
    axes_t axes;
  } stage_t;

endpackage

[design/hax_cell.sv]
// One bit-plane cell of the inverse undo chain.
// Depends on hax_pkg for the axes and stage types.
module hax_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [hax_pkg::PLANE_W-1:0] plane,
  input  logic [hax_pkg::DIM_W-1:0]   eff_n,
  input  logic [hax_pkg::BITS_W-1:0]  eff_b,
  input  hax_pkg::stage_t             up_stage,
  output logic                        up_ready,
  output hax_pkg::stage_t             dn_stage,
  input  logic                        dn_ready
);

  logic                                  valid_r;
  hax_pkg::axes_t                        axes_r;
  hax_pkg::axes_t                        axes_nxt;
  logic [hax_pkg::COORD_BITS-1:0]        low;
  logic [hax_pkg::COORD_BITS-1:0]        sw;
  logic                                  active;

  assign active   = {1'b0, plane} < eff_b;
  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    for (int j = 0; j < hax_pkg::COORD_BITS; j++) begin
      low[j] = j < int'(plane);
    end
  end

  // walk the axes in order; axis 0 is inverted or exchanged below this plane
  always_comb begin
    axes_nxt = up_stage.axes;
    sw       = '0;
    if (active) begin
      for (int i = 0; i < hax_pkg::MAX_DIMS; i++) begin
        if (i < int'(eff_n)) begin
          if (axes_nxt[i][plane]) begin
            axes_nxt[0] = axes_nxt[0] ^ low;
          end else begin
            sw          = (axes_nxt[0] ^ axes_nxt[i]) & low;
            axes_nxt[0] = axes_nxt[0] ^ sw;
            axes_nxt[i] = axes_nxt[i] ^ sw;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_stage.valid) begin
      axes_r <= axes_nxt;
    end
  end

  assign dn_stage.valid = valid_r;
  assign dn_stage.axes  = axes_r;

endmodule

[design/hax_gray.sv]
// Gray encode across the axes plus the parity correction, one registered stage.
// Depends on hax_pkg for the axes and stage types.
module hax_gray (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [hax_pkg::DIM_W-1:0]  eff_n,
  input  hax_pkg::stage_t            up_stage,
  output logic                       up_ready,
  output hax_pkg::stage_t            dn_stage,
  input  logic                       dn_ready
);

  logic                            valid_r;
  hax_pkg::axes_t                  axes_r;
  hax_pkg::axes_t                  gray;
  hax_pkg::axes_t                  axes_nxt;
  hax_pkg::coord_t                 last;
  hax_pkg::coord_t                 par;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    gray    = up_stage.axes;
    for (int i = 1; i < hax_pkg::MAX_DIMS; i++) begin
      if (i < int'(eff_n)) begin
        gray[i] = up_stage.axes[i] ^ gray[i-1];
      end
    end
    last = gray[0];
    for (int i = 1; i < hax_pkg::MAX_DIMS; i++) begin
      if (i == int'(eff_n) - 1) begin
        last = gray[i];
      end
    end
    // parity bit j is the xor of all bits of the last axis above j
    par = '0;
    for (int j = hax_pkg::COORD_BITS - 2; j >= 0; j--) begin
      par[j] = par[j+1] ^ last[j+1];
    end
    axes_nxt = gray;
    for (int i = 0; i < hax_pkg::MAX_DIMS; i++) begin
      if (i < int'(eff_n)) begin
        axes_nxt[i] = gray[i] ^ par;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_stage.valid) begin
      axes_r <= axes_nxt;
    end
  end

  assign dn_stage.valid = valid_r;
  assign dn_stage.axes  = axes_r;

endmodule

[design/hilbert_axes_to_index_top.sv]
// Hilbert encoder top: config registers, input mask stage, chain of
// bit-plane cells, Gray stage and interleaving output register.
// Registered stages from input request to result: mask stage, 15 plane
// cells, Gray stage, output register. Throughput: one point per cycle;
// a stage holds its request only while its successor is full and stalled.
// Sync active-low reset empties the pipeline; num_dims = 2, bits_per_axis = 16.
module hilbert_axes_to_index_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hax_pkg::COORD_BITS-1:0] in_coord_0,
  input  logic [hax_pkg::COORD_BITS-1:0] in_coord_1,
  input  logic [hax_pkg::COORD_BITS-1:0] in_coord_2,
  input  logic [hax_pkg::COORD_BITS-1:0] in_coord_3,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hax_pkg::IDX_W-1:0]     out_hilbert_index,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hax_pkg::ADDR_W-1:0]    paddr,
  input  logic [hax_pkg::DATA_W-1:0]    pwdata,
  output logic [hax_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [hax_pkg::DIM_W-1:0]  num_dims_r;
  logic [hax_pkg::BITS_W-1:0] bits_r;
  logic [hax_pkg::DIM_W-1:0]  eff_n;
  logic [hax_pkg::BITS_W-1:0] eff_b;
  logic                       cfg_wr;

  // ---------------- config port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= hax_pkg::DIM_W'(2);
      bits_r     <= hax_pkg::BITS_W'(16);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        hax_pkg::REG_NUM_DIMS: num_dims_r <= pwdata[hax_pkg::DIM_W-1:0];
        hax_pkg::REG_BITS:     bits_r     <= pwdata[hax_pkg::BITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      hax_pkg::REG_NUM_DIMS: prdata = hax_pkg::DATA_W'(num_dims_r);
      hax_pkg::REG_BITS:     prdata = hax_pkg::DATA_W'(bits_r);
      default:               prdata = '0;
    endcase
  end

  // saturate out-of-range settings
  always_comb begin
    if (num_dims_r == '0) begin
      eff_n = hax_pkg::DIM_W'(1);
    end else if (num_dims_r > hax_pkg::DIM_W'(hax_pkg::MAX_DIMS)) begin
      eff_n = hax_pkg::DIM_W'(hax_pkg::MAX_DIMS);
    end else begin
      eff_n = num_dims_r;
    end
    if (bits_r == '0) begin
      eff_b = hax_pkg::BITS_W'(1);
    end else if (bits_r > hax_pkg::BITS_W'(hax_pkg::COORD_BITS)) begin
      eff_b = hax_pkg::BITS_W'(hax_pkg::COORD_BITS);
    end else begin
      eff_b = bits_r;
    end
  end

  // ---------------- input mask stage ----------------
  hax_pkg::stage_t in_stage;
  hax_pkg::axes_t  in_axes;
  hax_pkg::axes_t  mask_axes;
  logic            s0_valid_r;
  hax_pkg::axes_t  s0_axes_r;
  logic            s0_ready;

  hax_pkg::stage_t chain [hax_pkg::NUM_CELLS+1];
  logic            chain_rdy [hax_pkg::NUM_CELLS+1];

  assign in_axes = {in_coord_3, in_coord_2, in_coord_1, in_coord_0};

  always_comb begin
    for (int i = 0; i < hax_pkg::MAX_DIMS; i++) begin
      for (int j = 0; j < hax_pkg::COORD_BITS; j++) begin
        mask_axes[i][j] = in_axes[i][j] && (i < int'(eff_n)) && (j < int'(eff_b));
      end
    end
  end

  assign s0_ready = !s0_valid_r || chain_rdy[0];
  assign in_stall = !s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_valid) begin
      s0_axes_r <= mask_axes;
    end
  end

  assign in_stage.valid = s0_valid_r;
  assign in_stage.axes  = s0_axes_r;
  assign chain[0]       = in_stage;

  // ---------------- plane cells, top plane first ----------------
  for (genvar k = 0; k < hax_pkg::NUM_CELLS; k++) begin : g_cell
    hax_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .plane    (hax_pkg::PLANE_W'(hax_pkg::COORD_BITS - 1 - k)),
      .eff_n    (eff_n),
      .eff_b    (eff_b),
      .up_stage (chain[k]),
      .up_ready (chain_rdy[k]),
      .dn_stage (chain[k+1]),
      .dn_ready (chain_rdy[k+1])
    );
  end

  // ---------------- Gray stage ----------------
  hax_pkg::stage_t gray_stage;
  logic            out_ready;

  hax_gray u_gray (
    .clk      (clk),
    .rst_n    (rst_n),
    .eff_n    (eff_n),
    .up_stage (chain[hax_pkg::NUM_CELLS]),
    .up_ready (chain_rdy[hax_pkg::NUM_CELLS]),
    .dn_stage (gray_stage),
    .dn_ready (out_ready)
  );

  // ---------------- interleave and output register ----------------
  logic                      out_valid_r;
  logic [hax_pkg::IDX_W-1:0] index_r;
  logic [hax_pkg::IDX_W-1:0] lv [hax_pkg::MAX_DIMS];
  logic [hax_pkg::IDX_W-1:0] index_nxt;

  assign out_ready = !out_valid_r || !out_stall;

  // bit p*n + n-1-i holds bit p of axis i, one candidate per dimension count
  always_comb begin
    for (int nv = 1; nv <= hax_pkg::MAX_DIMS; nv++) begin
      lv[nv-1] = '0;
      for (int p = 0; p < hax_pkg::COORD_BITS; p++) begin
        for (int i = 0; i < nv; i++) begin
          lv[nv-1][p*nv + nv - 1 - i] = gray_stage.axes[i][p];
        end
      end
    end
    index_nxt = lv[0];
    for (int nv = 2; nv <= hax_pkg::MAX_DIMS; nv++) begin
      if (nv == int'(eff_n)) begin
        index_nxt = lv[nv-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= gray_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && gray_stage.valid) begin
      index_r <= index_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hilbert_index = index_r;

endmodule

[tb/hilbert_axes_to_index_top_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for hilbert_axes_to_index_top: random points through
// the valid/stall channels, predicted Hilbert indexes checked in order.
// Depends on hax_pkg and the design top; APB config writes between phases.
module hilbert_axes_to_index_top_test;
  import hax_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 25;
  localparam int PHASE_ITEMS    = 82;
  localparam int NUM_PHASES     = 14;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [15:0]       in_coord_0, in_coord_1, in_coord_2, in_coord_3;
  logic              out_valid;
  logic              out_stall;
  logic [IDX_W-1:0]  out_hilbert_index;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  hilbert_axes_to_index_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coord_0(in_coord_0), .in_coord_1(in_coord_1),
    .in_coord_2(in_coord_2), .in_coord_3(in_coord_3),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hilbert_index(out_hilbert_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // current register contents as the predictor sees them
  logic [DIM_W-1:0]  nd_cfg;
  logic [BITS_W-1:0] bw_cfg;

  axes_t            point_q[$];
  logic [IDX_W-1:0] index_q[$];

  bit in_fire, out_fire;
  bit tx_burst, rx_burst;
  int tx_gap, rx_stall_left, rx_roll;
  int err_cnt, idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [IDX_W-1:0] hilbert_index_of(input axes_t pt,
                                                        input logic [DIM_W-1:0] nd_reg,
                                                        input logic [BITS_W-1:0] bw_reg);
    int n, b;
    coord_t mask, low, sw, par;
    coord_t ax [MAX_DIMS];
    logic [IDX_W-1:0] idx;
    n = (nd_reg == 0) ? 1 : (nd_reg > MAX_DIMS) ? MAX_DIMS : int'(nd_reg);
    b = (bw_reg == 0) ? 1 : (bw_reg > COORD_BITS) ? COORD_BITS : int'(bw_reg);
    mask = coord_t'((32'd1 << b) - 1);
    for (int i = 0; i < MAX_DIMS; i++)
      ax[i] = (i < n) ? (pt[i] & mask) : '0;
    // undo pass, top plane down to plane 1
    for (int qb = b - 1; qb >= 1; qb--) begin
      low = coord_t'((32'd1 << qb) - 1);
      for (int i = 0; i < n; i++) begin
        if (ax[i][qb]) begin
          ax[0] ^= low;
        end else begin
          sw = (ax[0] ^ ax[i]) & low;
          ax[0] ^= sw;
          ax[i] ^= sw;
        end
      end
    end
    for (int i = 1; i < n; i++)
      ax[i] ^= ax[i-1];
    // parity correction comes from the last axis in use
    par = '0;
    for (int qb = b - 1; qb >= 1; qb--)
      if (ax[n-1][qb]) par ^= coord_t'((32'd1 << qb) - 1);
    for (int i = 0; i < n; i++)
      ax[i] ^= par;
    idx = '0;
    for (int p = 0; p < b; p++)
      for (int i = 0; i < n; i++)
        idx[p*n + n-1-i] = ax[i][p];
    return idx;
  endfunction

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2: return coord_t'(1) << $urandom_range(0, COORD_BITS - 1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [IDX_W-1:0] want,
                                 input logic [IDX_W-1:0] got);
    $display("[%0t] index mismatch (%s): expected %h got %h", $realtime, what, want, got);
    err_cnt++;
  endtask

  // request driver
  always @(negedge clk) begin
    axes_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (point_q.size() > 0) begin
        cur = point_q.pop_front();
        in_coord_0 <= cur[0];
        in_coord_1 <= cur[1];
        in_coord_2 <= cur[2];
        in_coord_3 <= cur[3];
        in_valid <= 1'b1;
        tx_gap = pick_gap(tx_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_stall <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_burst || rx_roll < 65) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        rx_stall_left = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    logic [IDX_W-1:0] want;
    in_fire  = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (in_fire)
      index_q.push_back(hilbert_index_of({in_coord_3, in_coord_2, in_coord_1, in_coord_0},
                                         nd_cfg, bw_cfg));
    if (out_fire) begin
      if (index_q.size() == 0) begin
        report_mismatch("no request pending", '0, out_hilbert_index);
      end else begin
        want = index_q.pop_front();
        if (out_hilbert_index !== want) report_mismatch("hilbert_index", want, out_hilbert_index);
      end
    end
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no progress for %0d cycles", $realtime, idle_cycles);
      $display("hilbert_axes_to_index_top_test: FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (point_q.size() != 0 || index_q.size() != 0 || in_valid) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_idx == REG_NUM_DIMS) nd_cfg = val[DIM_W-1:0];
    else bw_cfg = val[BITS_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper data bits are random junk; only the low field bits matter
  task automatic set_mode(input int nd, input int bw);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_write(REG_NUM_DIMS, ($urandom & ~32'h7) | DATA_W'(nd));
    cfg_write(REG_BITS, ($urandom & ~32'h1F) | DATA_W'(bw));
  endtask

  task automatic push_random(input int count);
    axes_t pt;
    for (int k = 0; k < count; k++) begin
      for (int a = 0; a < MAX_DIMS; a++) pt[a] = rand_coord();
      point_q.push_back(pt);
    end
  endtask

  int mode_dims [NUM_PHASES] = '{1, 4, 4, 3, 0, 7, 5, 1, 2, 3, 4, 2, 6, 4};
  int mode_bits [NUM_PHASES] = '{1, 16, 1, 7, 0, 31, 17, 16, 1, 16, 9, 5, 12, 16};

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_coord_0 = '0; in_coord_1 = '0; in_coord_2 = '0; in_coord_3 = '0;
    out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    nd_cfg = 3'd2;
    bw_cfg = 5'd16;
    tx_burst = 1'b0; rx_burst = 1'b0;
    tx_gap = 0; rx_stall_left = 0;
    err_cnt = 0; idle_cycles = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed points under the reset mode (2 axes, 16 bits)
    point_q.push_back({16'h0000, 16'h0000, 16'h0000, 16'h0000});
    point_q.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    point_q.push_back({16'h0000, 16'h0000, 16'h0000, 16'h8000});
    point_q.push_back({16'h0000, 16'h0000, 16'h8000, 16'h0000});
    point_q.push_back({16'h8000, 16'h8000, 16'h0000, 16'h0000});
    point_q.push_back({16'h0000, 16'h0000, 16'h0000, 16'h0001});
    point_q.push_back({16'h0000, 16'h0000, 16'h0001, 16'h0000});
    point_q.push_back({16'h0000, 16'h0000, 16'h0001, 16'h0001});
    point_q.push_back({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
    point_q.push_back({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    point_q.push_back({16'h0000, 16'h0000, 16'hFFFF, 16'h0000});
    point_q.push_back({16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
    point_q.push_back({16'h1234, 16'hFEDC, 16'h7FFF, 16'h8000});
    point_q.push_back({16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE});
    point_q.push_back({16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00});
    point_q.push_back({16'h0000, 16'h0000, 16'h0003, 16'h0002});

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_mode(mode_dims[ph], mode_bits[ph]);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (ph % 2 == 1) begin
        // sender holds off until the pipeline has fully drained
        push_random(PHASE_ITEMS / 2);
        wait_drained();
        push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        push_random(PHASE_ITEMS);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("hilbert_axes_to_index_top_test: PASS");
    end else begin
      $display("hilbert_axes_to_index_top_test: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/hax_pkg.sv
design/hax_cell.sv
design/hax_gray.sv
design/hilbert_axes_to_index_top.sv
tb/hilbert_axes_to_index_top_test.sv
